@@ design/bpc_pkg.sv @@
// Shared types and constants of the button press classifier.
// No dependencies; every other design file depends on this package.
package bpc_pkg;

  localparam int unsigned TimeW  = 32;
  localparam int unsigned MsW    = 16;
  localparam int unsigned ShiftW = 8;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_DEBOUNCE_MS   = 3'd0,
    CFG_LONG_PRESS_MS = 3'd1,
    CFG_REPEAT_MS     = 3'd2,
    CFG_SHORT_SHIFT   = 3'd3,
    CFG_LONG_SHIFT    = 3'd4
  } bpc_cfg_idx_e;

  localparam logic [MsW-1:0]    DebounceRst   = 16'd50;
  localparam logic [MsW-1:0]    LongPressRst  = 16'd500;
  localparam logic [MsW-1:0]    RepeatRst     = 16'd200;
  localparam logic [ShiftW-1:0] ShortShiftRst = 8'sd1;
  localparam logic [ShiftW-1:0] LongShiftRst  = 8'sd1;

  typedef struct packed {
    logic [MsW-1:0]           debounce_ms;
    logic [MsW-1:0]           long_press_ms;
    logic [MsW-1:0]           repeat_interval_ms;
    logic signed [ShiftW-1:0] short_shift;
    logic signed [ShiftW-1:0] long_shift;
  } bpc_cfg_t;

  typedef struct packed {
    logic                     event_valid;
    logic signed [ShiftW-1:0] shift_count;
  } bpc_res_t;

endpackage

@@ design/bpc_poll_if.sv @@
// Valid/ready channel carrying one poll of the button.
// Depends on bpc_pkg for field widths.
interface bpc_poll_if;
  logic                       valid;
  logic                       ready;
  logic                       raw_level;
  logic [bpc_pkg::TimeW-1:0]  now_ms;

  modport source (output valid, output raw_level, output now_ms, input ready);
  modport sink   (input valid, input raw_level, input now_ms, output ready);
endinterface

@@ design/bpc_event_if.sv @@
// Valid/ready channel carrying one classification result.
// Depends on bpc_pkg for field widths.
interface bpc_event_if;
  logic                              valid;
  logic                              ready;
  logic                              event_valid;
  logic signed [bpc_pkg::ShiftW-1:0] shift_count;

  modport source (output valid, output event_valid, output shift_count, input ready);
  modport sink   (input valid, input event_valid, input shift_count, output ready);
endinterface

@@ design/bpc_cfg_regs.sv @@
// Configuration register bank of the button press classifier.
// Depends on bpc_pkg for register indexes, reset values and bpc_cfg_t.
module bpc_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [bpc_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [bpc_pkg::CfgDataW-1:0]     cfg_wdata_i,
  output bpc_pkg::bpc_cfg_t                cfg_o
);
  import bpc_pkg::*;

  bpc_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ms        <= DebounceRst;
      cfg_q.long_press_ms      <= LongPressRst;
      cfg_q.repeat_interval_ms <= RepeatRst;
      cfg_q.short_shift        <= ShortShiftRst;
      cfg_q.long_shift         <= LongShiftRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DEBOUNCE_MS:   cfg_q.debounce_ms        <= cfg_wdata_i;
        CFG_LONG_PRESS_MS: cfg_q.long_press_ms      <= cfg_wdata_i;
        CFG_REPEAT_MS:     cfg_q.repeat_interval_ms <= cfg_wdata_i;
        CFG_SHORT_SHIFT:   cfg_q.short_shift        <= cfg_wdata_i[ShiftW-1:0];
        CFG_LONG_SHIFT:    cfg_q.long_shift         <= cfg_wdata_i[ShiftW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ design/bpc_core.sv @@
// Debounce and press classification state with its next-state logic.
// Depends on bpc_pkg; the state advances by one poll whenever adv_i is high.
module bpc_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        adv_i,
  input  logic                        raw_level_i,
  input  logic [bpc_pkg::TimeW-1:0]   now_ms_i,
  input  bpc_pkg::bpc_cfg_t           cfg_i,
  output bpc_pkg::bpc_res_t           res_o
);
  import bpc_pkg::*;

  logic             prev_raw_q, stable_q, long_q;
  logic [TimeW-1:0] bounce_q, press_q, repeat_q;
  logic             stable_d, long_d;
  logic [TimeW-1:0] bounce_d, press_d, repeat_d;

  logic             raw_moved, change, press_edge, release_edge, long_mid;
  logic             short_fire, long_fire, rep_fire;
  logic [TimeW-1:0] bounce_diff, press_diff, press_diff_old, repeat_diff;
  logic [TimeW-1:0] debounce_w, long_press_w, repeat_w;

  always_comb begin
    debounce_w   = {{(TimeW-MsW){1'b0}}, cfg_i.debounce_ms};
    long_press_w = {{(TimeW-MsW){1'b0}}, cfg_i.long_press_ms};
    repeat_w     = {{(TimeW-MsW){1'b0}}, cfg_i.repeat_interval_ms};

    // A raw level change restarts the bounce window at the current time.
    raw_moved   = (raw_level_i != prev_raw_q);
    bounce_d    = raw_moved ? now_ms_i : bounce_q;
    bounce_diff = raw_moved ? '0 : (now_ms_i - bounce_q);

    change       = (bounce_diff > debounce_w) && (raw_level_i != stable_q);
    stable_d     = change ? raw_level_i : stable_q;
    press_edge   = change && !raw_level_i;
    release_edge = change && raw_level_i;

    press_diff_old = now_ms_i - press_q;
    short_fire     = release_edge && !long_q && (press_diff_old >= debounce_w);

    long_mid   = change ? 1'b0 : long_q;
    press_d    = press_edge ? now_ms_i : press_q;
    press_diff = press_edge ? '0 : press_diff_old;
    long_fire  = !stable_d && !long_mid && (press_diff > long_press_w);
    long_d     = long_fire | long_mid;

    // Repeats only run on a long press already active before this poll.
    repeat_diff = now_ms_i - repeat_q;
    rep_fire    = !change && !stable_q && long_q && (repeat_diff >= repeat_w);
    repeat_d    = (long_fire || rep_fire) ? now_ms_i : repeat_q;

    res_o.event_valid = short_fire | long_fire | rep_fire;
    if (short_fire) begin
      res_o.shift_count = cfg_i.short_shift;
    end else if (long_fire || rep_fire) begin
      res_o.shift_count = cfg_i.long_shift;
    end else begin
      res_o.shift_count = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_raw_q <= 1'b1;
      stable_q   <= 1'b1;
      long_q     <= 1'b0;
      bounce_q   <= '0;
      press_q    <= '0;
      repeat_q   <= '0;
    end else if (adv_i) begin
      prev_raw_q <= raw_level_i;
      stable_q   <= stable_d;
      long_q     <= long_d;
      bounce_q   <= bounce_d;
      press_q    <= press_d;
      repeat_q   <= repeat_d;
    end
  end

endmodule

@@ design/button_press_classifier_top.sv @@
// Top level of the button press classifier: poll register, core, result register.
// Depends on bpc_pkg, bpc_poll_if, bpc_event_if, bpc_cfg_regs and bpc_core.
//
// Takes one poll (raw active-low button level and a 32-bit millisecond
// timestamp) per clock cycle while the result side does not stall, and returns
// exactly one result per poll, telling whether that poll produced a short, long
// or repeat press event and its configured shift count. A poll is held in an
// input register and classified against the debounce state once the result
// register is free; its result is captured in the output register together
// with the state update of that poll, and is offered from then on, so polls
// may follow each other every cycle while results are taken. Stalls on the
// result side back up through the two registers. Configuration writes are to
// be made only while no poll is in flight.
module button_press_classifier_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [bpc_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [bpc_pkg::CfgDataW-1:0]     cfg_wdata_i,
  bpc_poll_if.sink                         poll_i,
  bpc_event_if.source                      event_o
);
  import bpc_pkg::*;

  logic             in_valid_q, out_valid_q;
  logic             raw_q;
  logic [TimeW-1:0] now_q;
  bpc_res_t         res_d, res_q;
  bpc_cfg_t         cfg;
  logic             adv;

  // The core advances when a poll is held and the result register is free.
  assign adv          = in_valid_q && (!out_valid_q || event_o.ready);
  assign poll_i.ready = !in_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (poll_i.ready) begin
        in_valid_q <= poll_i.valid;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (event_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (poll_i.valid && poll_i.ready) begin
      raw_q <= poll_i.raw_level;
      now_q <= poll_i.now_ms;
    end
    if (adv) begin
      res_q <= res_d;
    end
  end

  bpc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  bpc_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .raw_level_i (raw_q),
    .now_ms_i    (now_q),
    .cfg_i       (cfg),
    .res_o       (res_d)
  );

  assign event_o.valid       = out_valid_q;
  assign event_o.event_valid = res_q.event_valid;
  assign event_o.shift_count = res_q.shift_count;

endmodule
